>>> rtl/spq_pkg.sv
// spq_pkg: shared types and codes for the stable priority queue.
// Used by spq_cell, stable_priority_queue_unit and spq_checker.
// No dependencies.
package spq_pkg;

  localparam int PRI_W = 16;
  localparam int PAY_W = 32;
  localparam int OCC_W = 5;

  typedef enum logic {
    CMD_INSERT  = 1'b0,
    CMD_EXTRACT = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_FULL      = 2'd1,
    ST_EXTRACTED = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef struct packed {
    logic [PRI_W-1:0] priority_val;
    logic [PAY_W-1:0] payload_val;
  } entry_t;

  // Broadcast to every cell of the row.
  typedef struct packed {
    logic   ins;      // insert this cycle
    logic   ext;      // extract head this cycle
    entry_t new_ent;  // word being inserted
  } cell_ctrl_t;

endpackage

>>> rtl/spq_cell.sv
// spq_cell: one slot of the sorted row.
// Depends on spq_pkg. Holds one entry; shifts right on insert, left on extract.
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  logic               occ,        // slot holds a live entry
  input  logic               left_keep,  // left neighbour keeps its entry
  input  spq_pkg::entry_t    left_ent,
  input  spq_pkg::entry_t    right_ent,
  output logic               keep,
  output spq_pkg::entry_t    ent
);
  import spq_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;

  // Live and not above the new priority: stays put (keeps arrival order).
  assign keep = occ && (ent_r.priority_val <= ctrl.new_ent.priority_val);
  assign ent  = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (ctrl.ins) begin
      if (!keep) begin
        ent_nxt = left_keep ? ctrl.new_ent : left_ent;
      end
    end else if (ctrl.ext) begin
      ent_nxt = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

>>> rtl/stable_priority_queue_unit.sv
// stable_priority_queue_unit: top level, bounded stable min-priority queue.
// Depends on spq_pkg and spq_cell; a row of DEPTH cells kept in sorted order.
//
//  channel | direction | ports
//  --------+-----------+--------------------------------------------------------
//  in      | input     | in_valid, in_stall, in_command, in_priority_in, in_payload_in
//  out     | output    | out_valid, out_stall, out_status, out_priority_out,
//          |           | out_payload_out, out_occupancy
//
// Cycles: one word per cycle while in_stall is low; every cell updates in the
// same cycle the word is taken, and the result sits in the output register on
// the next cycle.
// Reset: rst_n clears entry count and output valid; the cell contents need none.
// Stalls: a new word is taken while the output register is empty or being
// drained, so out_stall reaches in_stall in the same cycle.
module stable_priority_queue_unit #(
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_command,
  input  logic [spq_pkg::PRI_W-1:0]  in_priority_in,
  input  logic signed [spq_pkg::PAY_W-1:0] in_payload_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_status,
  output logic [spq_pkg::PRI_W-1:0]  out_priority_out,
  output logic signed [spq_pkg::PAY_W-1:0] out_payload_out,
  output logic [spq_pkg::OCC_W-1:0]  out_occupancy
);
  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  // Entry count, occupancy is taken modulo 32.
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic [31:0]   count_wide;

  // Output register.
  logic             out_valid_r, out_valid_nxt;
  status_t          status_r, status_nxt;
  logic [PRI_W-1:0] pri_out_r, pri_out_nxt;
  logic [PAY_W-1:0] pay_out_r, pay_out_nxt;
  logic [OCC_W-1:0] occ_out_r, occ_out_nxt;

  logic       accept;
  logic       full;
  logic       empty;
  cell_ctrl_t ctrl;

  // Cell row wiring.
  logic   [DEPTH-1:0] occ;
  logic   [DEPTH-1:0] keep;
  entry_t             ent [DEPTH];

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);

  assign ctrl.ins = accept && (cmd_t'(in_command) == CMD_INSERT) && !full;
  assign ctrl.ext = accept && (cmd_t'(in_command) == CMD_EXTRACT) && !empty;
  assign ctrl.new_ent.priority_val = in_priority_in;
  assign ctrl.new_ent.payload_val  = in_payload_in;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic   lk;
      entry_t le;
      entry_t re;
      assign occ[g] = (count_r > CW'(g));
      if (g == 0) begin : g_head
        // Nothing ahead of the head: an insert that displaces it lands here.
        assign lk = 1'b1;
        assign le = ctrl.new_ent;
      end else begin : g_body
        assign lk = keep[g-1];
        assign le = ent[g-1];
      end
      if (g == DEPTH - 1) begin : g_tail
        assign re = ent[g];
      end else begin : g_mid
        assign re = ent[g+1];
      end
      spq_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .occ       (occ[g]),
        .left_keep (lk),
        .left_ent  (le),
        .right_ent (re),
        .keep      (keep[g]),
        .ent       (ent[g])
      );
    end
  endgenerate

  // Count and result for the word being taken.
  always_comb begin
    count_nxt   = count_r;
    status_nxt  = status_r;
    pri_out_nxt = pri_out_r;
    pay_out_nxt = pay_out_r;
    if (accept) begin
      pri_out_nxt = '0;
      pay_out_nxt = '0;
      if (cmd_t'(in_command) == CMD_INSERT) begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt = ST_INSERTED;
          count_nxt  = count_r + CW'(1);
        end
      end else if (empty) begin
        status_nxt = ST_EMPTY;
      end else begin
        // Head of the sorted row is the earliest of the smallest priority.
        status_nxt  = ST_EXTRACTED;
        pri_out_nxt = ent[0].priority_val;
        pay_out_nxt = ent[0].payload_val;
        count_nxt   = count_r - CW'(1);
      end
    end
  end

  assign count_wide  = 32'(count_nxt);
  assign occ_out_nxt = accept ? count_wide[OCC_W-1:0] : occ_out_r;

  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    pri_out_r <= pri_out_nxt;
    pay_out_r <= pay_out_nxt;
    occ_out_r <= occ_out_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_priority_out = pri_out_r;
  assign out_payload_out  = pay_out_r;
  assign out_occupancy    = occ_out_r;

endmodule

>>> rtl/spq_checker.sv
// spq_checker: port-level checks for stable_priority_queue_unit.
// Depends on spq_pkg; bound to the top level at the end of this file.
module spq_checker #(
  parameter int DEPTH = 16
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [1:0]                 out_status,
  input logic [spq_pkg::PRI_W-1:0]  out_priority_out,
  input logic signed [spq_pkg::PAY_W-1:0] out_payload_out,
  input logic [spq_pkg::OCC_W-1:0]  out_occupancy
);
  import spq_pkg::*;

  localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(DEPTH);

  // Every accepted word yields a result word next cycle.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted word produced no result");

  // A stalled result holds.
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_status)
      && $stable(out_priority_out) && $stable(out_payload_out)
      && $stable(out_occupancy)))
    else $error("stalled result changed");

  // Only an extraction carries an entry.
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_EXTRACTED))
      |-> (out_priority_out == '0 && out_payload_out == '0))
    else $error("non-extract result carries data");

  // Empty report leaves nothing held; full report leaves DEPTH held.
  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_EMPTY) |-> (out_occupancy == '0))
    else $error("empty reported with entries held");

  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> (out_occupancy == FULL_OCC))
    else $error("full reported below capacity");

endmodule

bind stable_priority_queue_unit spq_checker #(.DEPTH(DEPTH)) u_spq_checker (.*);

>>> tb/tb.sv
// tb: self-checking testbench for stable_priority_queue_unit.
// Depends on spq_pkg and the RTL; carries its own predictor of the stable
// min-priority queue and checks every result word field by field.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int DEPTH         = 16;
  localparam int HOLD_CYCLES   = 150;   // long receiver hold-off
  localparam int IDLE_LIMIT    = 2000;  // cycles with no word moving on either side
  localparam int SETTLE_CYCLES = 8;     // tail after the last result
  localparam int MAX_REPORTS   = 40;
  localparam int RANDOM_WORDS  = 1250;

  // Priority shapes for the random part
  typedef enum int {PRI_ANY, PRI_TIES, PRI_EDGE, PRI_BAND} pri_mode_t;
  // Receiver stall patterns
  typedef enum int {RX_FREE, RX_LIGHT, RX_PERIODIC, RX_HEAVY} rx_mode_t;

  typedef struct {
    status_t                  status;
    logic [PRI_W-1:0]         pri;
    logic signed [PAY_W-1:0]  pay;
    logic [OCC_W-1:0]         occ;
  } qresult_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic                      in_command;
  logic [PRI_W-1:0]          in_priority_in;
  logic signed [PAY_W-1:0]   in_payload_in;
  logic                      out_valid;
  logic                      out_stall;
  logic [1:0]                out_status;
  logic [PRI_W-1:0]          out_priority_out;
  logic signed [PAY_W-1:0]   out_payload_out;
  logic [OCC_W-1:0]          out_occupancy;

  stable_priority_queue_unit #(.DEPTH(DEPTH)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_priority_in   (in_priority_in),
    .in_payload_in    (in_payload_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_priority_out (out_priority_out),
    .out_payload_out  (out_payload_out),
    .out_occupancy    (out_occupancy)
  );

  // Shadow of the queue contents, kept in arrival order
  logic [PRI_W-1:0]        shadow_pri[$];
  logic signed [PAY_W-1:0] shadow_pay[$];
  // Results predicted but not yet seen on the output
  qresult_t                due_results[$];

  int error_count  = 0;
  int idle_cycles  = 0;
  int words_taken  = 0;
  int words_given  = 0;
  int n_inserted   = 0;
  int n_dropped    = 0;
  int n_extracted  = 0;
  int n_empty      = 0;
  int peak_occ     = 0;

  // Sender burst control
  bit gaps_on    = 1'b1;
  int burst_left = 0;
  // Set by a test to make the receiver hold off for HOLD_CYCLES
  bit hold_req   = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor: applies one accepted word to the shadow queue.
  // Extract takes the first entry holding the smallest priority, so equal
  // priorities leave in arrival order; the entries behind it close the gap.
  // --------------------------------------------------------------------------
  function automatic qresult_t predict_result(cmd_t cmd, logic [PRI_W-1:0] pri,
                                              logic signed [PAY_W-1:0] pay);
    qresult_t r;
    int       best;
    r.pri = '0;
    r.pay = '0;
    if (cmd == CMD_INSERT) begin
      if (shadow_pri.size() >= DEPTH) begin
        r.status = ST_FULL;      // dropped, queue untouched
        n_dropped++;
      end else begin
        shadow_pri.push_back(pri);
        shadow_pay.push_back(pay);
        r.status = ST_INSERTED;
        n_inserted++;
      end
    end else if (shadow_pri.size() == 0) begin
      r.status = ST_EMPTY;       // nothing to hand out
      n_empty++;
    end else begin
      best = 0;
      for (int i = 1; i < shadow_pri.size(); i++) begin
        if (shadow_pri[i] < shadow_pri[best]) best = i;  // strict: earliest wins ties
      end
      r.pri = shadow_pri[best];
      r.pay = shadow_pay[best];
      shadow_pri.delete(best);
      shadow_pay.delete(best);
      r.status = ST_EXTRACTED;
      n_extracted++;
    end
    r.occ = OCC_W'(shadow_pri.size());
    if (shadow_pri.size() > peak_occ) peak_occ = shadow_pri.size();
    return r;
  endfunction

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: everything sampled at the rising edge, before the DUT's own
  // updates land. The result check runs ahead of the prediction so a spurious
  // word can never be matched with a word taken at the same edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    qresult_t exp_r;
    bit       moved;
    moved = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        words_given++;
        if (due_results.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t ns: result word with none expected, expected nothing, got status %0d",
                     $time, out_status);
        end else begin
          exp_r = due_results.pop_front();
          check_field("status",    32'(exp_r.status), 32'(out_status));
          check_field("priority",  32'(exp_r.pri),    32'(out_priority_out));
          check_field("payload",   32'(exp_r.pay),    32'(out_payload_out));
          check_field("occupancy", 32'(exp_r.occ),    32'(out_occupancy));
        end
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        words_taken++;
        due_results.push_back(predict_result(cmd_t'(in_command), in_priority_in,
                                             in_payload_in));
      end
    end
    if (moved) idle_cycles = 0;
    else       idle_cycles++;
  end

  initial begin : watchdog
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("%0t ns: no word moved for %0d cycles", $time, IDLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: segments of random length, each with its own stall pattern,
  // one of them never stalling. A hold request overrides for HOLD_CYCLES.
  // --------------------------------------------------------------------------
  initial begin : receiver
    rx_mode_t mode;
    int       seg_left;
    int       hold_left;
    int       tick;
    mode      = RX_FREE;
    seg_left  = 0;
    hold_left = 0;
    tick      = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall = 1'b1;
      end else begin
        if (seg_left == 0) begin
          mode     = rx_mode_t'($urandom_range(0, 3));
          seg_left = $urandom_range(20, 200);
        end
        seg_left--;
        tick++;
        case (mode)
          RX_FREE:     out_stall = 1'b0;
          RX_LIGHT:    out_stall = ($urandom_range(0, 99) < 30);
          RX_PERIODIC: out_stall = (tick % 3 == 0);
          default:     out_stall = ($urandom_range(0, 99) < 75);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender: one word per call, valid left high so bursts run back to back.
  // With gaps on, valid drops for a random pause between bursts.
  // --------------------------------------------------------------------------
  task automatic send_word(cmd_t cmd, logic [PRI_W-1:0] pri, logic signed [PAY_W-1:0] pay);
    int gap;
    if (gaps_on && burst_left == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap - 1) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_command     = cmd;
    in_priority_in = pri;
    in_payload_in  = pay;
    in_valid       = 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [PRI_W-1:0] pick_priority(pri_mode_t mode);
    case (mode)
      PRI_TIES: return PRI_W'($urandom_range(0, 3));
      PRI_BAND: return PRI_W'($urandom_range(100, 131));
      PRI_EDGE: begin
        case ($urandom_range(0, 3))
          0:       return 16'h0000;
          1:       return 16'h0001;
          2:       return 16'hFFFE;
          default: return 16'hFFFF;
        endcase
      end
      default:  return PRI_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // ---------------------------- tests ---------------------------------------

  // Extract straight after reset: empty, and no stale entry may be read
  task automatic test_empty_extract();
    send_word(CMD_EXTRACT, 16'h1234, 32'h0BAD_F00D);
  endtask

  // Priority and payload extremes, ties at both ends, then one extract too many
  task automatic test_extremes();
    send_word(CMD_INSERT, 16'hFFFF, 32'h7FFF_FFFF);
    send_word(CMD_INSERT, 16'h0000, 32'h8000_0000);
    send_word(CMD_INSERT, 16'h0000, 32'hFFFF_FFFF);
    send_word(CMD_INSERT, 16'hFFFF, 32'h0000_0000);
    send_word(CMD_INSERT, 16'h8000, 32'h5555_5555);
    repeat (5) send_word(CMD_EXTRACT, 16'hFFFF, 32'hAAAA_AAAA);
    send_word(CMD_EXTRACT, 16'h0000, 32'h0000_0000);
  endtask

  // Equal priorities must leave in arrival order, also after a gap closes
  task automatic test_stable_ties();
    send_word(CMD_INSERT, 16'd7, 32'd1);
    send_word(CMD_INSERT, 16'd3, 32'd2);
    send_word(CMD_INSERT, 16'd7, 32'd3);
    send_word(CMD_INSERT, 16'd3, 32'd4);
    send_word(CMD_INSERT, 16'd7, 32'd5);
    repeat (2) send_word(CMD_EXTRACT, 16'($urandom), $urandom);
    send_word(CMD_INSERT, 16'd3, 32'd6);
    send_word(CMD_INSERT, 16'd7, 32'd7);
    repeat (5) send_word(CMD_EXTRACT, 16'($urandom), $urandom);
  endtask

  // Fill to DEPTH, overflow a few times, then empty it and go two past
  task automatic test_full_and_overflow();
    drain();
    gaps_on = 1'b0;
    repeat (DEPTH) send_word(CMD_INSERT, pick_priority(PRI_TIES), $urandom);
    repeat (3)     send_word(CMD_INSERT, pick_priority(PRI_ANY), $urandom);
    repeat (DEPTH + 2) send_word(CMD_EXTRACT, 16'($urandom), $urandom);
    gaps_on = 1'b1;
  endtask

  // Receiver holds off for a long stretch while words keep coming,
  // so the output register fills and the input stalls
  task automatic test_backpressure();
    drain();
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    repeat (40) begin
      if ($urandom_range(0, 99) < 70)
        send_word(CMD_INSERT, pick_priority(PRI_ANY), $urandom);
      else
        send_word(CMD_EXTRACT, 16'($urandom), $urandom);
    end
    gaps_on = 1'b1;
    drain();
  endtask

  // Episodes of varied insert/extract mix and priority shape; an insert-heavy
  // run reaches full, an extract-heavy one reaches empty
  task automatic test_random_mix(int n_words);
    int        sent;
    int        len;
    int        ins_pct;
    pri_mode_t pmode;
    sent = 0;
    while (sent < n_words) begin
      len   = $urandom_range(10, 80);
      pmode = pri_mode_t'($urandom_range(0, 3));
      case ($urandom_range(0, 3))
        0:       ins_pct = 20;
        1:       ins_pct = 50;
        2:       ins_pct = 85;
        default: ins_pct = $urandom_range(0, 100);
      endcase
      gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) drain();
      for (int k = 0; k < len && sent < n_words; k++) begin
        if ($urandom_range(0, 99) < ins_pct)
          send_word(CMD_INSERT, pick_priority(pmode), $urandom);
        else
          send_word(CMD_EXTRACT, 16'($urandom), $urandom);
        sent++;
      end
    end
    gaps_on = 1'b1;
  endtask

  // ---------------------------- sequence ------------------------------------
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_command     = CMD_INSERT;
    in_priority_in = '0;
    in_payload_in  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_extract();
    test_extremes();
    test_stable_ties();
    test_full_and_overflow();
    test_backpressure();
    test_random_mix(RANDOM_WORDS);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d words in, %0d results out: %0d inserted, %0d dropped full,",
             words_taken, words_given, n_inserted, n_dropped);
    $display("%0d extracted, %0d on empty, peak occupancy %0d of %0d.",
             n_extracted, n_empty, peak_occ, DEPTH);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
